>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// Check a condition in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

>>> design/rcst_pkg.sv
// Package with constants, codes and types of the segment table.
package rcst_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_REFS      = 255;

   localparam int KEY_W    = 32;
   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W    = $clog2(MAX_REFS + 1);
   localparam int ENTRY_W  = KEY_W + CNT_W;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 6;
   localparam int REF_W    = 8;

   localparam logic OP_OPEN  = 1'b0;
   localparam logic OP_CLOSE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_ATTACHED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_LIMIT     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DETACHED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd6;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd7;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    idx;
      logic [CNT_W-1:0]    count;
   } res_type;

endpackage

>>> design/rcst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rcst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/rcst_engine.sv
// Scan and write-back sequencer around the entry memory.
module rcst_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rcst_pkg::req_type req,
   output logic              busy,
   output rcst_pkg::res_type res
);

   localparam int IDX_W = rcst_pkg::IDX_W;
   localparam int CNT_W = rcst_pkg::CNT_W;
   localparam int KEY_W = rcst_pkg::KEY_W;

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(rcst_pkg::TABLE_ENTRIES - 1);
   localparam logic [IDX_W:0]   ENTRIES_CNT = (IDX_W + 1)'(rcst_pkg::TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] MAX_CNT     = CNT_W'(rcst_pkg::MAX_REFS);
   localparam logic [CNT_W-1:0] ONE_CNT     = CNT_W'(1);

   logic [1:0]              state_ff,    state_in;
   rcst_pkg::req_type       req_ff,      req_in;
   logic [IDX_W:0]          issue_ff,    issue_in;
   logic [IDX_W-1:0]        clr_ff,      clr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]        rd_idx_ff,   rd_idx_in;
   logic                    hit_ff,      hit_in;
   logic [IDX_W-1:0]        hit_idx_ff,  hit_idx_in;
   logic [CNT_W-1:0]        hit_cnt_ff,  hit_cnt_in;
   logic                    free_ff,     free_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;

   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   logic [rcst_pkg::ENTRY_W-1:0]  wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   logic [rcst_pkg::ENTRY_W-1:0]  rd_data;
   logic [KEY_W-1:0]              rd_key;
   logic [CNT_W-1:0]              rd_cnt;

   assign rd_key = rd_data[rcst_pkg::ENTRY_W-1:CNT_W];
   assign rd_cnt = rd_data[CNT_W-1:0];

   rcst_ram #(
      .WIDTH(rcst_pkg::ENTRY_W),
      .DEPTH(rcst_pkg::TABLE_ENTRIES)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      issue_in    = issue_ff;
      clr_in      = clr_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_cnt_in  = hit_cnt_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      res         = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req;
               issue_in = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff < ENTRIES_CNT) begin
               rd_en    = 1'b1;
               rd_addr  = issue_ff[IDX_W-1:0];
               issue_in = issue_ff + 1'b1;
            end
            if (rd_valid_ff) begin
               if (rd_key == req_ff.key && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  hit_cnt_in = rd_cnt;
               end
               if (rd_key == '0 && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            res.valid = 1'b1;
            state_in  = S_IDLE;
            if (req_ff.op == rcst_pkg::OP_OPEN) begin
               if (hit_ff) begin
                  res.idx = hit_idx_ff;
                  if (hit_cnt_ff >= MAX_CNT) begin
                     res.status = rcst_pkg::ST_LIMIT;
                     res.count  = hit_cnt_ff;
                  end else begin
                     res.status = rcst_pkg::ST_ATTACHED;
                     res.count  = hit_cnt_ff + 1'b1;
                     wr_en      = 1'b1;
                     wr_addr    = hit_idx_ff;
                     wr_data    = {req_ff.key, res.count};
                  end
               end else if (free_ff) begin
                  res.status = rcst_pkg::ST_CREATED;
                  res.idx    = free_idx_ff;
                  res.count  = ONE_CNT;
                  wr_en      = 1'b1;
                  wr_addr    = free_idx_ff;
                  wr_data    = {req_ff.key, ONE_CNT};
               end else begin
                  res.status = rcst_pkg::ST_FULL;
               end
            end else begin
               if (!hit_ff) begin
                  res.status = rcst_pkg::ST_NOT_FOUND;
               end else if (hit_cnt_ff <= ONE_CNT) begin
                  res.status = rcst_pkg::ST_RELEASED;
                  res.idx    = hit_idx_ff;
                  wr_en      = 1'b1;
                  wr_addr    = hit_idx_ff;
               end else begin
                  res.status = rcst_pkg::ST_DETACHED;
                  res.idx    = hit_idx_ff;
                  res.count  = hit_cnt_ff - 1'b1;
                  wr_en      = 1'b1;
                  wr_addr    = hit_idx_ff;
                  wr_data    = {req_ff.key, res.count};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_valid_in = rd_en;
      rd_idx_in   = rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_cnt_ff  <= hit_cnt_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> design/refcounted_segment_table.sv
// Top level of the reference-counted segment table.
//
// Usage:
//   Request channel: drive req_opcode (open or close) and req_segment_id with
//   start high; the item is taken at a clock edge where start is high and busy
//   is low. Only one item is in flight at a time.
//   Response channel: rsp_strobe is high for exactly one cycle with rsp_status,
//   rsp_slot and rsp_ref_count valid; the receiver cannot stall it.
//   Processing: a nonzero id is scanned through the single read port of the
//   entry RAM, one read per entry, from acceptance to strobe: the last read
//   data returns, then the decision and write-back, then the response
//   register. busy stays high throughout and drops in the strobe cycle, so
//   a new item can be taken then.
//   Id 0 is answered as invalid in the next cycle without raising busy.
//   Reset: a clearing pass writes every entry free with a count of zero,
//   with busy high, before the first item is taken.
module refcounted_segment_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [rcst_pkg::KEY_W-1:0]          req_segment_id,
   output logic                                rsp_strobe,
   output logic [rcst_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rcst_pkg::SLOT_W-1:0]         rsp_slot,
   output logic [rcst_pkg::REF_W-1:0]          rsp_ref_count
);

   localparam int IDX_W  = rcst_pkg::IDX_W;
   localparam int CNT_W  = rcst_pkg::CNT_W;
   localparam int SLOT_W = rcst_pkg::SLOT_W;
   localparam int REF_W  = rcst_pkg::REF_W;

   logic                           accept;
   logic                           invalid;
   logic                           eng_start;
   logic                           eng_busy;
   rcst_pkg::req_type              eng_req;
   rcst_pkg::res_type              eng_res;
   logic [SLOT_W+IDX_W-1:0]        slot_wide;
   logic [REF_W+CNT_W-1:0]         count_wide;

   logic                           strobe_ff, strobe_in;
   logic [rcst_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic [SLOT_W-1:0]              slot_ff,   slot_in;
   logic [REF_W-1:0]               count_ff,  count_in;

   assign accept    = start && !eng_busy;
   assign invalid   = (req_segment_id == '0);
   assign eng_start = accept && !invalid;
   assign eng_req   = '{op: req_opcode, key: req_segment_id};

   rcst_engine u_engine (
      .clock(clock),
      .reset(reset),
      .start(eng_start),
      .req  (eng_req),
      .busy (eng_busy),
      .res  (eng_res)
   );

   assign slot_wide  = {{SLOT_W{1'b0}}, eng_res.idx};
   assign count_wide = {{REF_W{1'b0}}, eng_res.count};

   always_comb begin
      strobe_in = 1'b0;
      status_in = status_ff;
      slot_in   = slot_ff;
      count_in  = count_ff;
      if (accept && invalid) begin
         strobe_in = 1'b1;
         status_in = rcst_pkg::ST_INVALID;
         slot_in   = '0;
         count_in  = '0;
      end else if (eng_res.valid) begin
         strobe_in = 1'b1;
         status_in = eng_res.status;
         slot_in   = slot_wide[SLOT_W-1:0];
         count_in  = count_wide[REF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      slot_ff   <= slot_in;
      count_ff  <= count_in;
   end

   assign busy          = eng_busy;
   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_slot      = slot_ff;
   assign rsp_ref_count = count_ff;

endmodule

>>> design/rcst_checker.sv
// Port-level checker for the segment table, bound to the top level.
`include "assert_macros.svh"

module rcst_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_opcode,
   input logic [rcst_pkg::KEY_W-1:0]    req_segment_id,
   input logic                          rsp_strobe,
   input logic [rcst_pkg::STATUS_W-1:0] rsp_status,
   input logic [rcst_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [rcst_pkg::REF_W-1:0]    rsp_ref_count
);

   logic no_entry;
   logic opcode_seen;

   assign no_entry    = (rsp_slot == '0) && (rsp_ref_count == '0);
   assign opcode_seen = req_opcode || !req_opcode;

   `ASSERT_NEXT(a_invalid_next, clock, reset, start && !busy && req_segment_id == '0 && opcode_seen, rsp_strobe && rsp_status == rcst_pkg::ST_INVALID)
   `ASSERT_SAME(a_no_entry, clock, reset, rsp_strobe && (rsp_status == rcst_pkg::ST_INVALID || rsp_status == rcst_pkg::ST_FULL || rsp_status == rcst_pkg::ST_NOT_FOUND), no_entry)
   `ASSERT_SAME(a_created_one, clock, reset, rsp_strobe && rsp_status == rcst_pkg::ST_CREATED, rsp_ref_count == 8'd1)
   `ASSERT_SAME(a_released_zero, clock, reset, rsp_strobe && rsp_status == rcst_pkg::ST_RELEASED, rsp_ref_count == '0)
   `ASSERT_NEXT(a_busy_no_strobe, clock, reset, busy && !rsp_strobe && $past(busy), !rsp_strobe || !busy)

endmodule

bind refcounted_segment_table rcst_checker u_rcst_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_opcode    (req_opcode),
   .req_segment_id(req_segment_id),
   .rsp_strobe    (rsp_strobe),
   .rsp_status    (rsp_status),
   .rsp_slot      (rsp_slot),
   .rsp_ref_count (rsp_ref_count)
);
